// File: hw/rtl/four_bit_cpu_core_assert.svh
// assertion macros included by the core rtl file
`ifndef FOUR_BIT_CPU_CORE_ASSERT_SVH
`define FOUR_BIT_CPU_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define FBC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("four_bit_cpu_core assertion failed");

// antecedent implies consequent in the next cycle
`define FBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("four_bit_cpu_core assertion failed");

`else

`define FBC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/fbc_pkg.sv
package fbc_pkg;

    // default program store depth
    localparam int FBC_PROGRAM_DEPTH = 16;

    // instruction word bit positions
    localparam int BIT_J    = 7;
    localparam int BIT_C    = 6;
    localparam int BIT_D1   = 5;
    localparam int BIT_D0   = 4;
    localparam int BIT_SREG = 3;
    localparam int BIT_S    = 2;

    // stream word widths
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // operation selector on the input tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // destination codes
    typedef enum logic [1:0] {
        DEST_A    = 2'b00,
        DEST_B    = 2'b01,
        DEST_OUT  = 2'b10,
        DEST_NONE = 2'b11
    } t_dest;

    // decoded and executed instruction
    typedef struct packed {
        logic [3:0] val;
        logic [2:0] imm;
        logic       wr_a;
        logic       wr_b;
        logic       wr_out;
        logic       carry;
        logic       jump;
    } t_exec_res;

endpackage

// File: hw/rtl/fbc_ram.sv
module fbc_ram import fbc_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = FBC_PROGRAM_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/fbc_exec.sv
module fbc_exec import fbc_pkg::*; (
    input  logic [7:0] i_word,
    input  logic [3:0] i_a,
    input  logic [3:0] i_b,
    output t_exec_res  o_res
);

    logic [4:0] sum;
    logic [4:0] diff;
    logic [3:0] alu;
    logic       carry;
    t_dest      dest;

    // add or subtract with carry or borrow
    always_comb begin
        sum  = {1'b0, i_a} + {1'b0, i_b};
        diff = {1'b0, i_a} - {1'b0, i_b};
        if (i_word[BIT_S]) begin
            alu   = diff[3:0];
            carry = diff[4];
        end else begin
            alu   = sum[3:0];
            carry = sum[4];
        end
    end

    // destination decode and writeback selection
    always_comb begin
        dest         = t_dest'({i_word[BIT_D1], i_word[BIT_D0]});
        o_res        = '0;
        o_res.imm    = i_word[2:0];
        o_res.val    = i_word[BIT_SREG] ? {1'b0, i_word[2:0]} : alu;
        o_res.carry  = carry;
        o_res.jump   = i_word[BIT_J] | (i_word[BIT_C] & carry);
        case (dest)
            DEST_A: begin
                o_res.wr_a = 1'b1;
            end
            DEST_B: begin
                o_res.wr_b = 1'b1;
            end
            DEST_OUT: begin
                o_res.wr_out = 1'b1;
            end
            default: begin
                o_res.wr_a = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/four_bit_cpu_core.sv
// Four-bit processor core with a loadable program store.
// Input stream: i_s_tuser selects the operation (0 loads a program word,
// 1 executes one instruction); i_s_tdata carries the load address and word.
// Output stream: one word per input word, in order, reporting the output
// register, whether this step wrote it, the ALU carry, the program counter
// after the item and the stopped flag.
// An accepted word is read from the program store in its accept cycle,
// executed in the execute stage and then held in the output register.
// Throughput: one word per cycle while the receiver takes results; the
// next fetch address is formed from the word being executed, so fetch and
// execute overlap through the store's registered read.
// Reset clears the registers, the counter, the stopped flag and the valid
// bit of every store entry; entries never loaded read as zero.
// When the receiver stalls, the result stays in the output register, the
// instruction in execute waits, and the input stops accepting once both are
// occupied.
module four_bit_cpu_core import fbc_pkg::*; #(
    parameter int PROGRAM_DEPTH = FBC_PROGRAM_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,  // load_address[3:0], load_word[11:4], zero pad
    input  logic                  i_s_tuser,  // operation[0]
    // output stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata   // out_value[3:0], out_written[4], carry_flag[5],
                                              // next_pc[9:6], stopped[10], zero pad
);

    `include "four_bit_cpu_core_assert.svh"

    localparam int PC_W = $clog2(PROGRAM_DEPTH);
    localparam int LA_W = PC_W + 5;

    // architectural state
    logic [PC_W-1:0] r_pc;
    logic [3:0]      r_a;
    logic [3:0]      r_b;
    logic [3:0]      r_out;
    logic            r_halt;
    logic [PROGRAM_DEPTH-1:0] r_vld;

    // execute stage
    logic            r_e_valid;
    logic            r_e_op;
    logic            r_e_wvld;

    // output register
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_tdata;

    logic            s_fire;
    logic            e_fire;
    logic            out_free;
    logic            op;
    logic [3:0]      load_addr;
    logic [7:0]      load_word;
    logic [LA_W-1:0] la_ext;
    logic [LA_W-1:0] la_wrap;
    logic [PC_W-1:0] waddr;
    logic [PC_W-1:0] rd_pc;
    logic [7:0]      rdata;
    logic [7:0]      word;
    logic [PC_W-1:0] pc_adv;
    logic [PC_W+3:0] pc_ext;
    t_exec_res       ex;

    logic [PC_W-1:0] n_pc;
    logic [3:0]      n_a;
    logic [3:0]      n_b;
    logic [3:0]      n_out;
    logic            n_halt;
    logic            n_written;
    logic            n_carry;

    // handshake
    assign op        = i_s_tuser;
    assign load_addr = i_s_tdata[3:0];
    assign load_word = i_s_tdata[11:4];
    assign out_free  = !r_m_valid || i_m_tready;
    assign e_fire    = r_e_valid && out_free;
    assign o_s_tready = !r_e_valid || out_free;
    assign s_fire    = i_s_tvalid && o_s_tready;

    // load address at or above the store depth has the depth subtracted once
    always_comb begin
        la_ext  = LA_W'(load_addr);
        la_wrap = (la_ext >= LA_W'(PROGRAM_DEPTH)) ? la_ext - LA_W'(PROGRAM_DEPTH) : la_ext;
        waddr   = la_wrap[PC_W-1:0];
    end

    // fetch address follows the instruction leaving execute
    assign rd_pc = r_e_valid ? n_pc : r_pc;

    fbc_ram #(
        .WIDTH (8),
        .DEPTH (PROGRAM_DEPTH)
    ) u_prog (
        .i_clk   (i_clk),
        .i_we    (s_fire && (op == OP_LOAD)),
        .i_waddr (waddr),
        .i_wdata (load_word),
        .i_re    (s_fire && (op == OP_STEP)),
        .i_raddr (rd_pc),
        .o_rdata (rdata)
    );

    // never-loaded entries read as zero
    assign word = r_e_wvld ? rdata : 8'h00;

    fbc_exec u_exec (
        .i_word (word),
        .i_a    (r_a),
        .i_b    (r_b),
        .o_res  (ex)
    );

    // next architectural state for the item in execute
    always_comb begin
        pc_adv    = (r_pc == PC_W'(PROGRAM_DEPTH - 1)) ? '0 : r_pc + 1'b1;
        n_pc      = r_pc;
        n_a       = r_a;
        n_b       = r_b;
        n_out     = r_out;
        n_halt    = r_halt;
        n_written = 1'b0;
        n_carry   = 1'b0;
        if (r_e_op == OP_STEP && !r_halt) begin
            n_pc = pc_adv;
            if (word == 8'h00 && pc_adv > PC_W'(1)) begin
                n_halt = 1'b1;
            end else begin
                n_carry = ex.carry;
                if (ex.wr_a) begin
                    n_a = ex.val;
                end
                if (ex.wr_b) begin
                    n_b = ex.val;
                end
                if (ex.wr_out) begin
                    n_out     = r_a;
                    n_written = 1'b1;
                end
                if (ex.jump) begin
                    n_pc = PC_W'(ex.imm);
                end
            end
        end
        pc_ext = {4'b0000, n_pc};
    end

    // state, execute stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_a       <= '0;
            r_b       <= '0;
            r_out     <= '0;
            r_halt    <= 1'b0;
            r_vld     <= '0;
            r_e_valid <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (s_fire && (op == OP_LOAD)) begin
                r_vld[waddr] <= 1'b1;
            end
            if (e_fire) begin
                r_pc      <= n_pc;
                r_a       <= n_a;
                r_b       <= n_b;
                r_out     <= n_out;
                r_halt    <= n_halt;
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (s_fire) begin
                r_e_valid <= 1'b1;
            end else if (e_fire) begin
                r_e_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_e_op   <= op;
            r_e_wvld <= r_vld[rd_pc];
        end
        if (e_fire) begin
            r_m_tdata <= {5'b00000, n_halt, pc_ext[3:0], n_carry, n_written, n_out};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;

    // checks
    `FBC_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_halt, r_halt)
    `FBC_ASSERT_SAME(a_no_accept_when_blocked, i_clk, i_rst_n, r_e_valid && !out_free, !s_fire)
    `FBC_ASSERT_NEXT(a_halted_frozen, i_clk, i_rst_n, e_fire && r_halt,
        $stable(r_a) && $stable(r_b) && $stable(r_pc) && $stable(r_out))
    `FBC_ASSERT_NEXT(a_result_follows_exec, i_clk, i_rst_n, e_fire, r_m_valid)

endmodule

// File: test/tb.sv
module tb;
    import fbc_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AT_WORD = 500;
    localparam int MAX_SHOWN    = 10;
    localparam int DIR_ROWS     = 19;

    // one output word, split into its fields
    typedef struct packed {
        logic [3:0] out_value;
        logic       out_written;
        logic       carry_flag;
        logic [3:0] next_pc;
        logic       stopped;
    } t_cpu_report;

    // one row of the directed program, with the report where it is obvious
    typedef struct packed {
        logic        op;
        logic [3:0]  addr;
        logic [7:0]  word;
        logic        known;
        t_cpu_report rep;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // load_address[3:0], load_word[11:4], zero pad
    logic                  i_s_tuser;   // operation[0]
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // out_value[3:0], out_written[4], carry_flag[5],
                                        // next_pc[9:6], stopped[10], zero pad

    // shadow copy of the core state
    logic [7:0] prog_mem [FBC_PROGRAM_DEPTH];
    logic [3:0] pc_r;
    logic [3:0] reg_a_r;
    logic [3:0] reg_b_r;
    logic [3:0] reg_out_r;
    logic       halt_r;

    t_cpu_report report_q [$];

    int  mismatches    = 0;
    int  words_checked = 0;
    int  loads_sent    = 0;
    int  steps_sent    = 0;
    int  halted_steps  = 0;
    int  out_writes    = 0;
    int  carries       = 0;
    int  hold_left     = 0;
    int  cycle_count   = 0;
    bit  hold_done     = 1'b0;
    bit  steady        = 1'b0;

    // directed program: immediates, alu ops, every destination, jumps
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{OP_STEP, 4'd0,  8'h00, 1'b1, '{4'd0, 1'b0, 1'b0, 4'd1, 1'b0}},
        '{OP_LOAD, 4'd15, 8'hFF, 1'b1, '{4'd0, 1'b0, 1'b0, 4'd1, 1'b0}},
        '{OP_LOAD, 4'd1,  8'h0F, 1'b1, '{4'd0, 1'b0, 1'b0, 4'd1, 1'b0}},
        '{OP_STEP, 4'd0,  8'h00, 1'b1, '{4'd0, 1'b0, 1'b0, 4'd2, 1'b0}},
        '{OP_LOAD, 4'd2,  8'h1E, 1'b1, '{4'd0, 1'b0, 1'b0, 4'd2, 1'b0}},
        '{OP_STEP, 4'd0,  8'h00, 1'b1, '{4'd0, 1'b0, 1'b0, 4'd3, 1'b0}},
        '{OP_LOAD, 4'd3,  8'h40, 1'b1, '{4'd0, 1'b0, 1'b0, 4'd3, 1'b0}},
        '{OP_STEP, 4'd0,  8'h00, 1'b1, '{4'd0, 1'b0, 1'b0, 4'd4, 1'b0}},
        '{OP_LOAD, 4'd4,  8'h43, 1'b1, '{4'd0, 1'b0, 1'b0, 4'd4, 1'b0}},
        '{OP_STEP, 4'd0,  8'h00, 1'b1, '{4'd0, 1'b0, 1'b1, 4'd3, 1'b0}},
        '{OP_LOAD, 4'd3,  8'h64, 1'b1, '{4'd0, 1'b0, 1'b0, 4'd3, 1'b0}},
        '{OP_STEP, 4'd0,  8'h00, 1'b1, '{4'd3, 1'b1, 1'b1, 4'd4, 1'b0}},
        '{OP_LOAD, 4'd4,  8'hB9, 1'b1, '{4'd3, 1'b0, 1'b0, 4'd4, 1'b0}},
        '{OP_STEP, 4'd0,  8'h00, 1'b1, '{4'd3, 1'b0, 1'b0, 4'd1, 1'b0}},
        '{OP_STEP, 4'd0,  8'h00, 1'b1, '{4'd3, 1'b0, 1'b1, 4'd2, 1'b0}},
        '{OP_LOAD, 4'd0,  8'h00, 1'b1, '{4'd3, 1'b0, 1'b0, 4'd2, 1'b0}},
        '{OP_STEP, 4'd0,  8'h00, 1'b0, '0},
        '{OP_STEP, 4'd0,  8'h00, 1'b0, '0},
        '{OP_STEP, 4'd0,  8'h00, 1'b0, '0}
    };

    four_bit_cpu_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // apply one item to the shadow state and return the report it causes
    function automatic t_cpu_report predict_item(logic op, logic [3:0] addr, logic [7:0] word);
        t_cpu_report r;
        logic [7:0]  insn;
        logic [4:0]  sum;
        logic [3:0]  value;
        t_dest       dest;
        r = '0;
        if (op == OP_LOAD) begin
            prog_mem[addr] = word;
            loads_sent++;
        end else begin
            steps_sent++;
            if (halt_r) begin
                halted_steps++;
            end else begin
                insn = prog_mem[pc_r];
                pc_r = pc_r + 4'd1;
                // zero word halts unless the advanced counter is 0 or 1
                if (insn == 8'h00 && pc_r > 4'd1) begin
                    halt_r = 1'b1;
                end else begin
                    if (insn[BIT_S]) begin
                        sum = {1'b0, reg_a_r} - {1'b0, reg_b_r};
                        r.carry_flag = (reg_a_r < reg_b_r);
                    end else begin
                        sum = {1'b0, reg_a_r} + {1'b0, reg_b_r};
                        r.carry_flag = sum[4];
                    end
                    value = insn[BIT_SREG] ? {1'b0, insn[2:0]} : sum[3:0];
                    dest = t_dest'(insn[BIT_D1:BIT_D0]);
                    case (dest)
                        DEST_A: reg_a_r = value;
                        DEST_B: reg_b_r = value;
                        DEST_OUT: begin
                            reg_out_r = reg_a_r;
                            r.out_written = 1'b1;
                        end
                        default: ;
                    endcase
                    if (insn[BIT_J] || (insn[BIT_C] && r.carry_flag)) begin
                        pc_r = {1'b0, insn[2:0]};
                    end
                end
            end
        end
        r.out_value = reg_out_r;
        r.next_pc   = pc_r;
        r.stopped   = halt_r;
        out_writes += r.out_written;
        carries    += r.carry_flag;
        return r;
    endfunction

    function automatic void note_fail(string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("%s", msg);
        end
    endfunction

    // offer one word until accepted, then queue its report and maybe idle
    task automatic send_word(input logic op, input logic [3:0] addr, input logic [7:0] word,
                             input logic known, input t_cpu_report typed);
        t_cpu_report rep;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {4'b0000, word, addr};
        do @(posedge i_clk); while (!o_s_tready);
        rep = predict_item(op, addr, word);
        report_q.push_back(known ? typed : rep);
        if (!steady && $urandom_range(99) < 15) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
    endtask

    // result side: check each word, then pick next ready
    always @(posedge i_clk) begin
        t_cpu_report got;
        t_cpu_report want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.out_value   = o_m_tdata[3:0];
            got.out_written = o_m_tdata[4];
            got.carry_flag  = o_m_tdata[5];
            got.next_pc     = o_m_tdata[9:6];
            got.stopped     = o_m_tdata[10];
            if (report_q.size() == 0) begin
                note_fail($sformatf("unexpected word %h", o_m_tdata));
            end else begin
                want = report_q.pop_front();
                words_checked++;
                if (got.out_value !== want.out_value || got.out_written !== want.out_written ||
                    got.carry_flag !== want.carry_flag || got.next_pc !== want.next_pc ||
                    got.stopped !== want.stopped) begin
                    note_fail($sformatf(
                        "word %0d: out %h/%h wr %b/%b carry %b/%b pc %h/%h stop %b/%b (exp/got)",
                        words_checked, want.out_value, got.out_value, want.out_written,
                        got.out_written, want.carry_flag, got.carry_flag, want.next_pc,
                        got.next_pc, want.stopped, got.stopped));
                end
            end
        end
        // one long hold-off so the core fills up and stalls its input
        if (!hold_done && words_checked >= HOLD_AT_WORD) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= steady || ($urandom_range(99) >= 15);
        end
    end

    // stimulus
    initial begin
        logic       op;
        logic [3:0] addr;
        logic [7:0] word;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tuser  <= 1'b0;
        i_s_tdata  <= '0;
        i_m_tready <= 1'b0;
        foreach (prog_mem[k]) prog_mem[k] = 8'h00;
        pc_r      = 4'd0;
        reg_a_r   = 4'd0;
        reg_b_r   = 4'd0;
        reg_out_r = 4'd0;
        halt_r    = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed program
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_word(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].word,
                      dir_rows[i].known, dir_rows[i].rep);
        end
        wait_drained();

        // random programs, never fetching a halting word
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 250 && n < 400);
            if (n == 600) begin
                wait_drained();
            end
            op = ($urandom_range(99) < 30) ? OP_LOAD : OP_STEP;
            addr = 4'($urandom_range(15));
            if (op == OP_LOAD) begin
                case ($urandom_range(9))
                    0: begin
                        word = 8'h00;
                        // zero words at the wrap points still execute
                        if ($urandom_range(1)) addr = $urandom_range(1) ? 4'd0 : 4'd15;
                    end
                    1: word = 8'hFF;
                    default: begin
                        word = 8'($urandom_range(255));
                        if ($urandom_range(99) < 60) word[BIT_J] = 1'b0;
                    end
                endcase
            end else begin
                word = 8'($urandom_range(255));
                // a zero word here would stop the core: replace it first
                if (prog_mem[pc_r] == 8'h00 && pc_r != 4'd15 && pc_r != 4'd0) begin
                    op   = OP_LOAD;
                    addr = pc_r;
                    word = 8'($urandom_range(127, 1));
                end
            end
            send_word(op, addr, word, 1'b0, '0);
        end
        steady = 1'b0;
        wait_drained();

        // halt sequence: jump to 6, fetch a zero word, then items while stopped
        send_word(OP_LOAD, pc_r, 8'h86, 1'b0, '0);
        send_word(OP_STEP, 4'd0, 8'h00, 1'b0, '0);
        send_word(OP_LOAD, 4'd6, 8'h00, 1'b0, '0);
        send_word(OP_STEP, 4'd0, 8'h00, 1'b0, '0);
        send_word(OP_STEP, 4'd0, 8'h00, 1'b0, '0);
        send_word(OP_LOAD, 4'd15, 8'h5A, 1'b0, '0);
        send_word(OP_STEP, 4'd0, 8'h00, 1'b0, '0);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d program loads, %0d steps (%0d while stopped)",
                 loads_sent, steps_sent, halted_steps);
        $display("%0d output writes, %0d carries, %0d result words checked, %0d mismatches",
                 out_writes, carries, words_checked, mismatches);
        if (mismatches == 0 && report_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
